[rtl/nfps_pkg.sv]
// ----------------------------------------------------------------------------
// nfps_pkg
// Shared types and constants for the NAND flash page store: item formats,
// operation and status codes, the queue entry and the back-end state.
// ----------------------------------------------------------------------------
package nfps_pkg;

  // Field widths fixed by the item format.
  localparam int BLK_IDX_W = 8;
  localparam int PG_IDX_W  = 6;
  localparam int WORD_W    = 32;
  localparam int BLK_CNT_W = 9;
  localparam int PG_CNT_W  = 7;
  localparam int PTR_W     = 7;

  // Default array geometry.
  localparam int DEF_MAX_BLOCKS = 256;
  localparam int DEF_MAX_PAGES  = 64;

  // Reset values of the configuration registers.
  localparam logic [BLK_CNT_W-1:0] BLOCK_COUNT_RST = 9'd256;
  localparam logic [PG_CNT_W-1:0]  PAGE_COUNT_RST  = 7'd64;

  // Depth of the queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;

  // Operation codes.
  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_READ  = 2'd1,
    FN_ERASE = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  // Status codes returned with every result.
  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_BAD_BLOCK       = 3'd1,
    ST_BAD_PAGE        = 3'd2,
    ST_OUT_OF_ORDER    = 3'd3,
    ST_ALREADY_WRITTEN = 3'd4,
    ST_EMPTY_PAGE      = 3'd5,
    ST_ERASE_FREE      = 3'd6
  } status_t;

  // Input item.
  typedef struct packed {
    logic [1:0]           func;
    logic [BLK_IDX_W-1:0] block_index;
    logic [PG_IDX_W-1:0]  page_index;
    logic [WORD_W-1:0]    write_data;
    logic [WORD_W-1:0]    write_spare;
  } req_t;

  // Result item.
  typedef struct packed {
    logic [2:0]        status;
    logic [WORD_W-1:0] read_data;
    logic [WORD_W-1:0] read_spare;
  } rsp_t;

  // Classified item as held in the queue.
  typedef struct packed {
    req_t    item;
    status_t status;  // final status when no array access is needed
    logic    exec;    // item needs the pointer table and the page store
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_FETCH,
    BK_HOLD
  } back_state_t;

endpackage

[rtl/nfps_ram.sv]
// ----------------------------------------------------------------------------
// nfps_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module nfps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/nfps_front.sv]
// ----------------------------------------------------------------------------
// nfps_front
// Accepts items, checks the block and, for writes and reads, the page against
// the configured counts and queues each item with its early status for the back end.
// ----------------------------------------------------------------------------
module nfps_front #(
  parameter int MAX_BLOCKS = nfps_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_PAGES  = nfps_pkg::DEF_MAX_PAGES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  nfps_pkg::req_t                 req,
  input  logic [nfps_pkg::BLK_CNT_W-1:0] block_count,
  input  logic [nfps_pkg::PG_CNT_W-1:0]  page_count,
  output logic                           head_valid,
  output nfps_pkg::cmd_t                 head,
  input  logic                           pop
);
  import nfps_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic           blk_ok;
  logic           pg_ok;
  cmd_t           cmd;
  logic           push;
  cmd_t           entry [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  // Range checks; a count above the array size acts as the array size.
  assign blk_ok = ({1'b0, req.block_index} < block_count) &&
                  (32'(req.block_index) < MAX_BLOCKS);
  assign pg_ok  = ({1'b0, req.page_index} < page_count) &&
                  (32'(req.page_index) < MAX_PAGES);

  // Classify the item: settle it here or hand it on to the array.
  always_comb begin
    cmd.item   = req;
    cmd.status = ST_OK;
    cmd.exec   = 1'b0;
    case (func_t'(req.func))
      FN_WRITE, FN_READ: begin
        if (!blk_ok) begin
          cmd.status = ST_BAD_BLOCK;
        end else if (!pg_ok) begin
          cmd.status = ST_BAD_PAGE;
        end else begin
          cmd.exec = 1'b1;
        end
      end
      FN_ERASE: begin
        if (!blk_ok) begin
          cmd.status = ST_BAD_BLOCK;
        end else begin
          cmd.exec = 1'b1;
        end
      end
      default: begin
        cmd.status = ST_OK;
      end
    endcase
  end

  // Queue handshake.
  assign req_stall  = (count == QCW'(QUEUE_DEPTH));
  assign push       = req_valid && !req_stall;
  assign head_valid = (count != '0);
  assign head       = entry[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cmd;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (pop && head_valid) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      count <= count + QCW'(push) - QCW'(pop && head_valid);
    end
  end

endmodule

[rtl/nfps_back.sv]
// ----------------------------------------------------------------------------
// nfps_back
// Carries out queued items: looks up the block's write pointer, programs,
// reads or erases, and holds the result in the output register.
// ----------------------------------------------------------------------------
module nfps_back #(
  parameter int MAX_BLOCKS = nfps_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_PAGES  = nfps_pkg::DEF_MAX_PAGES
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  nfps_pkg::cmd_t head,
  output logic           pop,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output nfps_pkg::rsp_t rsp
);
  import nfps_pkg::*;

  // Only blocks and pages that an index field can reach are stored.
  localparam int NUM_BLK = (MAX_BLOCKS < (1 << BLK_IDX_W)) ? MAX_BLOCKS : (1 << BLK_IDX_W);
  localparam int NUM_PG  = (MAX_PAGES < (1 << PG_IDX_W)) ? MAX_PAGES : (1 << PG_IDX_W);
  localparam int BLK_AW  = (NUM_BLK > 1) ? $clog2(NUM_BLK) : 1;
  localparam int PG_AW   = (NUM_PG > 1) ? $clog2(NUM_PG) : 1;
  localparam int ST_AW   = BLK_AW + PG_AW;
  localparam int ST_DEPTH = NUM_BLK * (1 << PG_AW);

  back_state_t             state;
  back_state_t             state_next;
  cmd_t                    cur;
  cmd_t                    cur_next;
  rsp_t                    rsp_next;
  logic [NUM_BLK-1:0]      ptr_valid;
  logic                    ptr_re;
  logic                    ptr_we;
  logic [PTR_W-1:0]        ptr_wdata;
  logic [PTR_W-1:0]        ptr_rdata;
  logic [PTR_W-1:0]        ptr_cur;
  logic [PTR_W-1:0]        page_ext;
  logic [BLK_AW-1:0]       cur_blk;
  logic [ST_AW-1:0]        st_addr;
  logic                    st_we;
  logic                    st_re;
  logic [2*WORD_W-1:0]     st_rdata;

  assign cur_blk  = cur.item.block_index[BLK_AW-1:0];
  assign st_addr  = {cur_blk, cur.item.page_index[PG_AW-1:0]};
  assign page_ext = PTR_W'(cur.item.page_index);

  // A block whose pointer was never written since reset is free.
  assign ptr_cur = ptr_valid[cur_blk] ? ptr_rdata : '0;

  // Write pointer per block.
  nfps_ram #(
    .WIDTH (PTR_W),
    .DEPTH (NUM_BLK),
    .AW    (BLK_AW)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (cur_blk),
    .wdata (ptr_wdata),
    .re    (ptr_re),
    .raddr (head.item.block_index[BLK_AW-1:0]),
    .rdata (ptr_rdata)
  );

  // Data and spare words, one entry per page.
  nfps_ram #(
    .WIDTH (2 * WORD_W),
    .DEPTH (ST_DEPTH),
    .AW    (ST_AW)
  ) u_store_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_addr),
    .wdata ({cur.item.write_data, cur.item.write_spare}),
    .re    (st_re),
    .raddr (st_addr),
    .rdata (st_rdata)
  );

  // State register and pointer valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      ptr_valid <= '0;
    end else begin
      state <= state_next;
      if (ptr_we) begin
        ptr_valid[cur_blk] <= 1'b1;
      end
    end
  end

  // Current item and output register.
  always_ff @(posedge clk) begin
    cur <= cur_next;
    rsp <= rsp_next;
  end

  assign rsp_valid = (state == BK_HOLD);

  // Sequencer: next state and array controls.
  always_comb begin
    state_next = state;
    cur_next   = cur;
    rsp_next   = rsp;
    pop        = 1'b0;
    ptr_re     = 1'b0;
    ptr_we     = 1'b0;
    ptr_wdata  = '0;
    st_we      = 1'b0;
    st_re      = 1'b0;
    case (state)
      BK_IDLE: begin
        if (head_valid) begin
          pop      = 1'b1;
          cur_next = head;
          if (head.exec) begin
            ptr_re     = 1'b1;
            state_next = BK_LOOK;
          end else begin
            rsp_next.status     = head.status;
            rsp_next.read_data  = '0;
            rsp_next.read_spare = '0;
            state_next          = BK_HOLD;
          end
        end
      end
      BK_LOOK: begin
        rsp_next.status     = ST_OK;
        rsp_next.read_data  = '0;
        rsp_next.read_spare = '0;
        state_next          = BK_HOLD;
        case (func_t'(cur.item.func))
          FN_ERASE: begin
            if (ptr_cur == '0) begin
              rsp_next.status = ST_ERASE_FREE;
            end else begin
              ptr_we = 1'b1;
            end
          end
          FN_WRITE: begin
            if (ptr_cur == page_ext) begin
              st_we     = 1'b1;
              ptr_we    = 1'b1;
              ptr_wdata = ptr_cur + PTR_W'(1);
            end else if (ptr_cur < page_ext) begin
              rsp_next.status = ST_OUT_OF_ORDER;
            end else begin
              rsp_next.status = ST_ALREADY_WRITTEN;
            end
          end
          FN_READ: begin
            if (ptr_cur <= page_ext) begin
              rsp_next.status = ST_EMPTY_PAGE;
            end else begin
              st_re      = 1'b1;
              state_next = BK_FETCH;
            end
          end
          default: begin
            rsp_next.status = ST_OK;
          end
        endcase
      end
      BK_FETCH: begin
        rsp_next.status     = ST_OK;
        rsp_next.read_data  = st_rdata[2*WORD_W-1:WORD_W];
        rsp_next.read_spare = st_rdata[WORD_W-1:0];
        state_next          = BK_HOLD;
      end
      BK_HOLD: begin
        if (!rsp_stall) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

endmodule

[rtl/nand_flash_page_store_unit.sv]
// ----------------------------------------------------------------------------
// nand_flash_page_store_unit
// NAND flash array model with strictly sequential page programming, a
// write pointer per block and a status code for every access.
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/req_stall  req  (nfps_pkg::req_t)
//   rsp       out        rsp_valid/rsp_stall  rsp  (nfps_pkg::rsp_t)
//   config    in         APB psel/penable     block_count @0, page_count @4
//
// The back end takes one item at a time. An item settled by the range checks
// goes straight to the output register; other items wait for the registered
// pointer read, and a read returning data also waits for the page store read.
// The two-entry queue keeps taking items while a result waits in the output
// register. Reset clears the pointer valid flags at once, so no clearing pass
// is needed; page store contents are undefined until written.
// ----------------------------------------------------------------------------
module nand_flash_page_store_unit #(
  parameter int MAX_BLOCKS = nfps_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_PAGES  = nfps_pkg::DEF_MAX_PAGES
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  nfps_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output nfps_pkg::rsp_t rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import nfps_pkg::*;

  // Register indexes, taken from the word address.
  localparam logic REG_BLOCK_COUNT = 1'b0;
  localparam logic REG_PAGE_COUNT  = 1'b1;

  logic [BLK_CNT_W-1:0] block_count;
  logic [PG_CNT_W-1:0]  page_count;
  logic                 cfg_write;
  logic                 head_valid;
  cmd_t                 head;
  logic                 pop;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BLOCK_COUNT_RST;
      page_count  <= PAGE_COUNT_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_BLOCK_COUNT: block_count <= pwdata[BLK_CNT_W-1:0];
        REG_PAGE_COUNT:  page_count  <= pwdata[PG_CNT_W-1:0];
        default: begin
          block_count <= block_count;
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      REG_BLOCK_COUNT: prdata = 32'(block_count);
      REG_PAGE_COUNT:  prdata = 32'(page_count);
      default:         prdata = '0;
    endcase
  end

  // Front end: range checks and queue.
  nfps_front #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .MAX_PAGES  (MAX_PAGES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .block_count (block_count),
    .page_count  (page_count),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop)
  );

  // Back end: pointer table, page store and output register.
  nfps_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .MAX_PAGES  (MAX_PAGES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NAND flash page store. A queue of pending
// accesses feeds a clocked driver. A shadow of the array and the per-block
// write pointers predicts the status and read words of each accepted item,
// and a clocked monitor compares every result against the oldest
// prediction. Block and page counts are changed over the APB port between
// phases, once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb_top;
  import nfps_pkg::*;

  localparam logic [2:0] ADDR_BLOCK_COUNT = 3'd0;
  localparam logic [2:0] ADDR_PAGE_COUNT  = 3'd4;
  localparam int         IDLE_PCT         = 10;
  localparam int         HOLD_AFTER       = 150;
  localparam int         HOLD_CYCLES      = 120;
  localparam int         QUIET_CYCLES     = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req_item = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the array, the write pointers and the two count registers.
  bit [2*WORD_W-1:0]  shadow_pages [DEF_MAX_BLOCKS*DEF_MAX_PAGES];
  bit [PTR_W-1:0]     shadow_ptr [DEF_MAX_BLOCKS];
  logic [BLK_CNT_W-1:0] cfg_blocks = BLOCK_COUNT_RST;
  logic [PG_CNT_W-1:0]  cfg_pages  = PAGE_COUNT_RST;

  req_t queued_reqs [$];
  rsp_t awaited_rsps [$];
  int   error_count = 0;
  bit   steady_flow = 1'b0;
  int   results_seen = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  nand_flash_page_store_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Counts above the array size act as the array size.
  function automatic int unsigned blocks_in_use();
    return (cfg_blocks > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : cfg_blocks;
  endfunction

  function automatic int unsigned pages_in_use();
    return (cfg_pages > DEF_MAX_PAGES) ? DEF_MAX_PAGES : cfg_pages;
  endfunction

  // Applies one access to the shadow array and returns the result it gives.
  function automatic rsp_t flash_access(input req_t r);
    rsp_t        res;
    int unsigned slot;
    int unsigned ptr;
    res = '0;
    res.status = ST_OK;
    if (r.func != FN_NOP) begin
      if (r.block_index >= blocks_in_use()) begin
        res.status = ST_BAD_BLOCK;
      end else if (r.func == FN_ERASE) begin
        if (shadow_ptr[r.block_index] == 0) res.status = ST_ERASE_FREE;
        else shadow_ptr[r.block_index] = '0;
      end else if (r.page_index >= pages_in_use()) begin
        res.status = ST_BAD_PAGE;
      end else begin
        slot = r.block_index * DEF_MAX_PAGES + r.page_index;
        ptr  = 32'(shadow_ptr[r.block_index]);
        if (r.func == FN_WRITE) begin
          if (ptr == r.page_index) begin
            shadow_pages[slot] = {r.write_data, r.write_spare};
            shadow_ptr[r.block_index] = PTR_W'(ptr + 1);
          end else if (ptr < r.page_index) begin
            res.status = ST_OUT_OF_ORDER;
          end else begin
            res.status = ST_ALREADY_WRITTEN;
          end
        end else if (ptr <= r.page_index) begin
          res.status = ST_EMPTY_PAGE;
        end else begin
          {res.read_data, res.read_spare} = shadow_pages[slot];
        end
      end
    end
    return res;
  endfunction

  // Driver: presents queued items, holds a stalled item, idles now and then.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) awaited_rsps.push_back(flash_access(req_item));
      if (req_valid && req_stall) begin
        req_valid <= 1'b1;
      end else if (queued_reqs.size() != 0 &&
                   (steady_flow || $urandom_range(0, 99) >= IDLE_PCT)) begin
        req_item  <= queued_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result and drives the stall, with one long hold-off.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (awaited_rsps.size() == 0) begin
          $error("result item with no prediction waiting: status %0d", rsp_item.status);
          error_count++;
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_item.status);
            error_count++;
          end
          if (rsp_item.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, rsp_item.read_data);
            error_count++;
          end
          if (rsp_item.read_spare !== want.read_spare) begin
            $error("read_spare: expected %h, got %h", want.read_spare, rsp_item.read_spare);
            error_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // One APB write: setup phase, then access until pready.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      ADDR_BLOCK_COUNT: cfg_blocks = value[BLK_CNT_W-1:0];
      ADDR_PAGE_COUNT:  cfg_pages  = value[PG_CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_counts(input int unsigned blocks, input int unsigned pages);
    write_reg(ADDR_BLOCK_COUNT, blocks);
    write_reg(ADDR_PAGE_COUNT, pages);
  endtask

  task automatic add_item(input func_t f, input int unsigned blk, input int unsigned pg,
                          input logic [31:0] data, input logic [31:0] spare);
    req_t r;
    r.func        = f;
    r.block_index = blk[BLK_IDX_W-1:0];
    r.page_index  = pg[PG_IDX_W-1:0];
    r.write_data  = data;
    r.write_spare = spare;
    queued_reqs.push_back(r);
  endtask

  // Waits until every item has been sent and answered, then a little longer.
  // The state is sampled mid-cycle, once the driver and monitor have settled.
  task automatic settle();
    @(negedge clk);
    while (queued_reqs.size() != 0 || req_valid || awaited_rsps.size() != 0)
      @(negedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Mostly in-order programming, reads of written pages and occasional
  // erases on a few busy blocks; the rest is unconstrained noise.
  task automatic random_phase(input int n, input int unsigned focus);
    bit [PTR_W-1:0] aim [DEF_MAX_BLOCKS];
    int unsigned    nblk;
    int unsigned    npg;
    int unsigned    blk;
    int unsigned    top;
    int unsigned    roll;
    aim  = shadow_ptr;
    nblk = blocks_in_use();
    npg  = pages_in_use();
    if (focus > nblk) focus = nblk;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (nblk == 0 || roll >= 85) begin
        add_item(func_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                 $urandom_range(0, 63), $urandom(), $urandom());
      end else begin
        if ($urandom_range(0, 99) < 75) blk = $urandom_range(0, focus - 1);
        else blk = $urandom_range(0, nblk - 1);
        if (roll < 55 && aim[blk] < npg) begin
          add_item(FN_WRITE, blk, aim[blk], $urandom(), $urandom());
          aim[blk]++;
        end else if (roll < 55 || roll >= 80) begin
          add_item(FN_ERASE, blk, $urandom_range(0, 63), $urandom(), $urandom());
          aim[blk] = '0;
        end else begin
          top = (aim[blk] < npg) ? aim[blk] : npg;
          if (top == 0) add_item(FN_READ, blk, $urandom_range(0, 63), $urandom(), $urandom());
          else add_item(FN_READ, blk, $urandom_range(0, top - 1), $urandom(), $urandom());
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Pointer rules at the reset counts.
    add_item(FN_ERASE, 0, 0, 32'h0, 32'h0);
    add_item(FN_READ, 0, 0, 32'h0, 32'h0);
    add_item(FN_WRITE, 0, 1, 32'h1234_5678, 32'h9abc_def0);
    add_item(FN_WRITE, 0, 0, 32'hffff_ffff, 32'h0000_0000);
    add_item(FN_WRITE, 0, 0, 32'h5555_5555, 32'haaaa_aaaa);
    add_item(FN_READ, 0, 0, 32'h0, 32'h0);
    add_item(FN_WRITE, 255, 0, 32'h0000_0000, 32'hffff_ffff);
    add_item(FN_WRITE, 7, 0, $urandom(), $urandom());
    add_item(FN_WRITE, 7, 1, $urandom(), $urandom());
    add_item(FN_WRITE, 7, 2, $urandom(), $urandom());
    add_item(FN_NOP, 255, 63, 32'hffff_ffff, 32'hffff_ffff);
    add_item(FN_ERASE, 0, 63, 32'h0, 32'h0);
    add_item(FN_READ, 0, 0, 32'h0, 32'h0);
    add_item(FN_WRITE, 0, 0, 32'hdead_beef, 32'h0bad_f00d);
    add_item(FN_READ, 0, 0, 32'h0, 32'h0);
    settle();

    // Zero counts: every block bad, then every page bad.
    set_counts(0, 0);
    add_item(FN_WRITE, 0, 0, 32'h0, 32'h0);
    add_item(FN_READ, 255, 63, 32'h0, 32'h0);
    settle();
    set_counts(1, 0);
    add_item(FN_READ, 0, 0, 32'h0, 32'h0);
    add_item(FN_ERASE, 1, 0, 32'h0, 32'h0);
    settle();

    // Page count lowered below the pointer of block 7.
    set_counts(8, 1);
    add_item(FN_WRITE, 7, 0, 32'h0, 32'h0);
    add_item(FN_READ, 7, 0, 32'h0, 32'h0);
    add_item(FN_READ, 7, 1, 32'h0, 32'h0);
    add_item(FN_WRITE, 7, 1, 32'h0, 32'h0);
    add_item(FN_ERASE, 7, 0, 32'h0, 32'h0);
    settle();

    // Random phases over a spread of counts, one of them without idling.
    set_counts(256, 64);
    random_phase(140, 2);
    settle();
    steady_flow = 1'b1;
    set_counts(16, 8);
    random_phase(140, 16);
    settle();
    steady_flow = 1'b0;
    set_counts(511, 127);
    random_phase(120, 6);
    settle();
    set_counts(3, 2);
    random_phase(100, 3);
    settle();
    set_counts(200, 5);
    random_phase(100, 8);
    settle();

    repeat (QUIET_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(12 * 400000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
rtl/nfps_pkg.sv
rtl/nfps_ram.sv
rtl/nfps_front.sv
rtl/nfps_back.sv
rtl/nand_flash_page_store_unit.sv
tb/sv/tb_top.sv
